/* src/pvt_pkg.sv */
// Shared types, codes and constants of the priority voice table.
`default_nettype none
package pvt_pkg;
	localparam int VOICES = 16;
	localparam int SLOT_W = $clog2(VOICES);
	localparam int CNT_W = SLOT_W + 1;

	typedef enum logic [2:0] {
		OP_START, OP_STOP, OP_STOP_ALL, OP_SET_PARAM,
		OP_GET_PARAM, OP_NEXT_ID, OP_SET_HOOK, OP_GET_HOOK
	} op_t;

	localparam logic [3:0] PRM_GROUP    = 4'd0;
	localparam logic [3:0] PRM_PRIORITY = 4'd1;
	localparam logic [3:0] PRM_VOLUME   = 4'd2;
	localparam logic [3:0] PRM_PAN      = 4'd3;
	localparam logic [3:0] PRM_DETUNE   = 4'd4;
	localparam logic [3:0] PRM_PITCH    = 4'd5;
	localparam logic [3:0] PRM_USER     = 4'd6;
	localparam logic [3:0] PRM_COUNT    = 4'd7;
	localparam logic [3:0] PRM_RESERVED = 4'd8;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_BAD       = 2'd2;
	localparam logic [1:0] ST_NO_VOICE  = 2'd3;

	localparam logic [31:0] MAX7       = 32'h7f;
	localparam logic [31:0] GROUP_LIM  = 32'h10;
	localparam int          DETUNE_LIM = 9216;
	localparam logic [31:0] PITCH_MAX  = 32'hfff;
	localparam logic [31:0] HOOK_MAX   = 32'h80;
	localparam logic [6:0]  START_VOL  = 7'd127;
	localparam logic [6:0]  START_PAN  = 7'd64;

	// classified command handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] id;
		logic [3:0]  prm;
		logic [31:0] uval;
		logic [6:0]  pr;
		logic        bad;
	} cmd_t;

	typedef enum logic [1:0] {B_IDLE, B_SCAN, B_COMMIT, B_FINISH} bstate_t;
endpackage
`default_nettype wire

/* src/pvt_front.sv */
// Front end: accepts command beats, classifies them and queues them for the back end.
`default_nettype none
module pvt_front import pvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] sound_id,
	input  wire logic [3:0]  param,
	input  wire logic [31:0] value,
	output cmd_t             cmd,
	output logic             cmd_valid,
	input  wire logic        cmd_take
);
	cmd_t       cls;
	cmd_t       q_mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic signed [31:0] sval;

	assign sval = signed'(value);

	// priority clamp and argument range checks
	always_comb begin
		cls.op   = op_t'(operation);
		cls.id   = sound_id;
		cls.prm  = param;
		cls.uval = value;
		if (value[31])
			cls.pr = 7'd0;
		else if (value > MAX7)
			cls.pr = 7'd127;
		else
			cls.pr = value[6:0];
		cls.bad = 1'b0;
		unique case (op_t'(operation))
			OP_START: cls.bad = (sound_id == 32'd0);
			OP_SET_HOOK: cls.bad = (value > HOOK_MAX);
			OP_SET_PARAM: begin
				unique case (param)
					PRM_GROUP: cls.bad = (value >= GROUP_LIM);
					PRM_PRIORITY, PRM_VOLUME, PRM_PAN: cls.bad = (value > MAX7);
					PRM_DETUNE: cls.bad = (sval < -DETUNE_LIM) || (sval > DETUNE_LIM);
					PRM_PITCH: cls.bad = value[31] || (value > PITCH_MAX);
					PRM_USER: cls.bad = 1'b0;
					default: cls.bad = 1'b1;
				endcase
			end
			default: cls.bad = 1'b0;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rp_q];
	assign do_push   = push && !full;

	// two-entry command queue
	always_ff @(posedge clk) begin
		if (do_push)
			q_mem_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wp_q <= !wp_q;
			if (cmd_take && cmd_valid)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(cmd_take && cmd_valid);
		end
	end
endmodule
`default_nettype wire

/* src/pvt_back.sv */
// Back end: voice table, sequential scan over the slots, commit and result register.
`default_nettype none
module pvt_back import pvt_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cmd_t         cmd,
	input  wire logic         cmd_valid,
	output logic              cmd_take,
	input  wire logic [127:0] gains,
	input  wire logic         pop,
	output logic              empty,
	output logic [1:0]        status,
	output logic [31:0]       result_value,
	output logic [7:0]        effective_volume,
	output logic [3:0]        voice_slot
);
	localparam logic [SLOT_W-1:0] LAST = SLOT_W'(VOICES - 1);

	// voice table
	logic [31:0]       vid_q   [VOICES];
	logic [6:0]        vpri_q  [VOICES];
	logic [6:0]        vvol_q  [VOICES];
	logic [6:0]        vpan_q  [VOICES];
	logic [3:0]        vgrp_q  [VOICES];
	logic [14:0]       vdet_q  [VOICES];
	logic [31:0]       vusr_q  [VOICES];
	logic [7:0]        vhook_q [VOICES];
	logic [SLOT_W-1:0] vage_q  [VOICES];

	bstate_t state_q, state_d;
	cmd_t    cmd_q;
	logic [SLOT_W-1:0] idx_q;

	// scan results
	logic              free_found_q, best_found_q, hit_q;
	logic [SLOT_W-1:0] free_slot_q, vic_slot_q, best_slot_q;
	logic [6:0]        vic_pri_q;
	logic [SLOT_W-1:0] vic_age_q, best_age_q;
	logic [6:0]        best_pri_q, best_vol_q, best_pan_q;
	logic [3:0]        best_grp_q;
	logic [14:0]       best_det_q;
	logic [31:0]       best_usr_q;
	logic [7:0]        best_hook_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       nxt_q;

	// commit results
	logic [1:0]        st_q;
	logic [31:0]       rv_q;
	logic [SLOT_W-1:0] slot_q;
	logic              touch_q;
	logic [6:0]        ev_vol_q;
	logic [3:0]        ev_grp_q;

	logic        out_v_q;
	logic        can_out;
	logic [31:0] cur_id;
	logic        match;

	// commit decisions
	logic [1:0]        st_c;
	logic [31:0]       rv_c;
	logic [SLOT_W-1:0] s_c;
	logic              start_c, steal_c, wr_set_c, wr_hook_c, touch_c, clear_c;
	logic [6:0]        ev_vol_c;
	logic [3:0]        ev_grp_c;

	logic [7:0]  gain;
	logic [15:0] prod;

	assign cur_id   = vid_q[idx_q];
	assign match    = (cmd_q.id != 32'd0) && (cur_id == cmd_q.id);
	assign can_out  = !out_v_q || pop;
	assign cmd_take = (state_q == B_IDLE) && cmd_valid;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:   if (cmd_valid) state_d = B_SCAN;
			B_SCAN:   if (idx_q == LAST) state_d = B_COMMIT;
			B_COMMIT: state_d = B_FINISH;
			B_FINISH: if (can_out) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// scan: one slot per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			hit_q        <= 1'b0;
			cnt_q        <= '0;
			nxt_q        <= '0;
		end else if (state_q == B_IDLE) begin
			idx_q        <= '0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			hit_q        <= 1'b0;
			cnt_q        <= '0;
			nxt_q        <= '0;
		end else if (state_q == B_SCAN) begin
			idx_q <= idx_q + 1'b1;
			if (cur_id == 32'd0 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= idx_q;
			end
			if (idx_q == '0 || vpri_q[idx_q] < vic_pri_q ||
			    (vpri_q[idx_q] == vic_pri_q && vage_q[idx_q] > vic_age_q)) begin
				vic_slot_q <= idx_q;
				vic_pri_q  <= vpri_q[idx_q];
				vic_age_q  <= vage_q[idx_q];
			end
			if (match && (!best_found_q || vage_q[idx_q] < best_age_q)) begin
				best_found_q <= 1'b1;
				best_slot_q  <= idx_q;
				best_age_q   <= vage_q[idx_q];
				best_pri_q   <= vpri_q[idx_q];
				best_vol_q   <= vvol_q[idx_q];
				best_pan_q   <= vpan_q[idx_q];
				best_grp_q   <= vgrp_q[idx_q];
				best_det_q   <= vdet_q[idx_q];
				best_usr_q   <= vusr_q[idx_q];
				best_hook_q  <= vhook_q[idx_q];
			end
			if (match) begin
				cnt_q <= cnt_q + 1'b1;
				hit_q <= 1'b1;
			end
			if (cur_id != 32'd0 && cur_id > cmd_q.id && (nxt_q == 32'd0 || cur_id < nxt_q))
				nxt_q <= cur_id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take)
			cmd_q <= cmd;
	end

	// commit decision
	always_comb begin
		st_c      = ST_OK;
		rv_c      = '0;
		s_c       = best_slot_q;
		start_c   = 1'b0;
		steal_c   = 1'b0;
		wr_set_c  = 1'b0;
		wr_hook_c = 1'b0;
		clear_c   = 1'b0;
		touch_c   = 1'b0;
		ev_vol_c  = best_vol_q;
		ev_grp_c  = best_grp_q;
		unique case (cmd_q.op)
			OP_START: begin
				ev_vol_c = START_VOL;
				ev_grp_c = 4'd0;
				if (cmd_q.bad)
					st_c = ST_BAD;
				else if (free_found_q) begin
					s_c     = free_slot_q;
					start_c = 1'b1;
				end else if (cmd_q.pr < vic_pri_q)
					st_c = ST_NO_VOICE;
				else begin
					s_c     = vic_slot_q;
					start_c = 1'b1;
					steal_c = 1'b1;
				end
				touch_c = start_c;
			end
			OP_STOP: st_c = hit_q ? ST_OK : ST_NOT_FOUND;
			OP_STOP_ALL: clear_c = 1'b1;
			OP_SET_PARAM: begin
				if (!best_found_q)
					st_c = ST_NOT_FOUND;
				else if (cmd_q.bad)
					st_c = ST_BAD;
				else begin
					wr_set_c = 1'b1;
					touch_c  = 1'b1;
					if (cmd_q.prm == PRM_VOLUME) ev_vol_c = cmd_q.uval[6:0];
					if (cmd_q.prm == PRM_GROUP)  ev_grp_c = cmd_q.uval[3:0];
				end
			end
			OP_GET_PARAM: begin
				if (cmd_q.prm == PRM_COUNT)
					rv_c = 32'(cnt_q);
				else if (!best_found_q)
					st_c = ST_NOT_FOUND;
				else begin
					touch_c = 1'b1;
					unique case (cmd_q.prm)
						PRM_GROUP:    rv_c = 32'(best_grp_q);
						PRM_PRIORITY: rv_c = 32'(best_pri_q);
						PRM_VOLUME:   rv_c = 32'(best_vol_q);
						PRM_PAN:      rv_c = 32'(best_pan_q);
						PRM_DETUNE:   rv_c = {{17{best_det_q[14]}}, best_det_q};
						PRM_PITCH, PRM_RESERVED: rv_c = '0;
						PRM_USER:     rv_c = best_usr_q;
						default: begin
							st_c    = ST_BAD;
							touch_c = 1'b0;
						end
					endcase
				end
			end
			OP_NEXT_ID: rv_c = nxt_q;
			OP_SET_HOOK: begin
				if (cmd_q.bad)
					st_c = ST_BAD;
				else if (!best_found_q)
					st_c = ST_NOT_FOUND;
				else begin
					wr_hook_c = 1'b1;
					touch_c   = 1'b1;
				end
			end
			OP_GET_HOOK: begin
				if (!best_found_q)
					st_c = ST_NOT_FOUND;
				else begin
					rv_c    = 32'(best_hook_q);
					touch_c = 1'b1;
				end
			end
			default: st_c = ST_OK;
		endcase
	end

	// ids: stop frees during the scan, commit fills or clears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < VOICES; j++)
				vid_q[j] <= '0;
		end else if (state_q == B_SCAN && cmd_q.op == OP_STOP && match) begin
			vid_q[idx_q] <= '0;
		end else if (state_q == B_COMMIT) begin
			if (clear_c)
				for (int j = 0; j < VOICES; j++)
					vid_q[j] <= '0;
			if (start_c)
				vid_q[s_c] <= cmd_q.id;
		end
	end

	// ages and voice fields
	always_ff @(posedge clk) begin
		if (state_q == B_SCAN && cmd_q.op == OP_STOP && match) begin
			for (int j = 0; j < VOICES; j++)
				if (vid_q[j] != 32'd0 && vage_q[j] > vage_q[idx_q])
					vage_q[j] <= vage_q[j] - 1'b1;
		end else if (state_q == B_COMMIT) begin
			if (start_c) begin
				for (int j = 0; j < VOICES; j++)
					if (vid_q[j] != 32'd0 && SLOT_W'(j) != s_c)
						vage_q[j] <= vage_q[j]
							- SLOT_W'(steal_c && vage_q[j] > vic_age_q) + 1'b1;
				vage_q[s_c]  <= '0;
				vpri_q[s_c]  <= cmd_q.pr;
				vvol_q[s_c]  <= START_VOL;
				vgrp_q[s_c]  <= 4'd0;
				vpan_q[s_c]  <= START_PAN;
				vdet_q[s_c]  <= '0;
				vusr_q[s_c]  <= '0;
				vhook_q[s_c] <= '0;
			end
			if (wr_hook_c)
				vhook_q[s_c] <= cmd_q.uval[7:0];
			if (wr_set_c) begin
				unique case (cmd_q.prm)
					PRM_GROUP:    vgrp_q[s_c] <= cmd_q.uval[3:0];
					PRM_PRIORITY: vpri_q[s_c] <= cmd_q.uval[6:0];
					PRM_VOLUME:   vvol_q[s_c] <= cmd_q.uval[6:0];
					PRM_PAN:      vpan_q[s_c] <= cmd_q.uval[6:0];
					PRM_DETUNE:   vdet_q[s_c] <= cmd_q.uval[14:0];
					PRM_USER:     vusr_q[s_c] <= cmd_q.uval;
					default:      vusr_q[s_c] <= vusr_q[s_c];
				endcase
			end
		end
	end

	// register commit outcome
	always_ff @(posedge clk) begin
		if (state_q == B_COMMIT) begin
			st_q     <= st_c;
			rv_q     <= (st_c == ST_OK) ? rv_c : '0;
			slot_q   <= s_c;
			touch_q  <= touch_c && (st_c == ST_OK);
			ev_vol_q <= ev_vol_c;
			ev_grp_q <= ev_grp_c;
		end
	end

	// effective volume
	assign gain = gains[{ev_grp_q, 3'b000} +: 8];
	assign prod = ({1'b0, ev_vol_q} + 8'd1) * gain;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (state_q == B_FINISH && can_out)
			out_v_q <= 1'b1;
		else if (pop)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == B_FINISH && can_out) begin
			status           <= st_q;
			result_value     <= rv_q;
			effective_volume <= touch_q ? prod[14:7] : 8'd0;
			voice_slot       <= touch_q ? slot_q[3:0] : 4'd0;
		end
	end

	assign empty = !out_v_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status != ST_OK) |-> (result_value == 32'd0 && effective_volume == 8'd0
			&& voice_slot == 4'd0))
		else $error("failed command carries nonzero result fields");
	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE) |-> (idx_q == '0))
		else $error("scan index not parked while idle");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(VOICES))
		else $error("match count beyond table size");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_FINISH && can_out) |=> out_v_q)
		else $error("finished command not presented");
endmodule
`default_nettype wire

/* src/priority_voice_table.sv */
// Top level: gain registers on the APB port, front end, back end.
// Command path: hand-off from the queue, scan over all 16 slots, commit, result register.
// The back end handles one command at a time, scans one slot per cycle, and takes the next command only when idle.
// A two-entry command queue takes beats while the back end is busy.
// Reset (arst_n low, asynchronous): all slots free, gains zero, queues empty.
`default_nettype none
module priority_voice_table import pvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] sound_id,
	input  wire logic [3:0]  param,
	input  wire logic [31:0] value,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       status,
	output logic [31:0]      result_value,
	output logic [7:0]       effective_volume,
	output logic [3:0]       voice_slot,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	logic [63:0] gains_low_q, gains_high_q;
	cmd_t        cmd;
	logic        cmd_valid, cmd_take;

	assign pready = 1'b1;
	assign prdata = paddr[3] ? gains_high_q : gains_low_q;

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_low_q  <= '0;
			gains_high_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[3])
				gains_high_q <= pwdata;
			else
				gains_low_q <= pwdata;
		end
	end

	pvt_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.operation(operation), .sound_id(sound_id), .param(param), .value(value),
		.cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
	);

	pvt_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_take(cmd_take), .gains({gains_high_q, gains_low_q}), .pop(pop),
		.empty(empty), .status(status), .result_value(result_value),
		.effective_volume(effective_volume), .voice_slot(voice_slot)
	);
endmodule
`default_nettype wire
